>>> hw/rtl/tmq_pkg.sv
// shared constants and types for the timed move queue
package tmq_pkg;

  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned OP_W    = 2;
  localparam int unsigned ACT_W   = 4;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned QCNT_W  = 4;

  localparam logic [TICK_W-1:0] HB_LIMIT_RESET = 16'd1000;
  localparam logic [TICK_W-1:0] TICK_MAX       = '1;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH      = 2'd0,
    OP_START     = 2'd1,
    OP_HEARTBEAT = 2'd2,
    OP_TICK      = 2'd3
  } op_e;

  typedef struct packed {
    logic capture;
    logic execute;
  } dp_cmd_t;

endpackage

>>> hw/rtl/tmq_req_if.sv
// input channel carrying move queue commands
interface tmq_req_if;
  import tmq_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [ACT_W-1:0]  move_action;
  logic [TICK_W-1:0] move_ticks;

  modport source (output valid, op, move_action, move_ticks, input ready);
  modport sink   (input valid, op, move_action, move_ticks, output ready);
endinterface

>>> hw/rtl/tmq_rsp_if.sv
// output channel carrying one result per command
interface tmq_rsp_if;
  import tmq_pkg::*;

  logic              valid;
  logic              ready;
  logic              push_taken;
  logic              motors_stopped;
  logic              move_started;
  logic [ACT_W-1:0]  started_action;
  logic              now_ready;
  logic              watchdog_fired;
  logic [QCNT_W-1:0] queued_count;

  modport source (output valid, push_taken, motors_stopped, move_started, started_action,
                  now_ready, watchdog_fired, queued_count, input ready);
  modport sink   (input valid, push_taken, motors_stopped, move_started, started_action,
                  now_ready, watchdog_fired, queued_count, output ready);
endinterface

>>> hw/rtl/tmq_ctrl.sv
// sequencing controller: capture, execute, hold result
module tmq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  output logic             rsp_valid_o,
  input  logic             rsp_ready_i,
  output tmq_pkg::dp_cmd_t cmd_o
);
  import tmq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_OUT
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (req_valid_i && in_ready_q) begin
            state_q    <= ST_EXEC;
            in_ready_q <= 1'b0;
          end
        end
        ST_EXEC: begin
          state_q     <= ST_OUT;
          out_valid_q <= 1'b1;
        end
        ST_OUT: begin
          if (rsp_ready_i) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b0;
            in_ready_q  <= 1'b1;
          end
        end
        default: begin
          state_q     <= ST_IDLE;
          in_ready_q  <= 1'b1;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

  assign req_ready_o   = in_ready_q;
  assign rsp_valid_o   = out_valid_q;
  assign cmd_o.capture = req_valid_i && in_ready_q;
  assign cmd_o.execute = (state_q == ST_EXEC);

  a_ready_valid_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_q && out_valid_q))
    else $error("input ready while result pending");

  a_capture_then_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> cmd_o.execute ##1 out_valid_q)
    else $error("captured transaction not executed");
endmodule

>>> hw/rtl/tmq_dp.sv
// datapath: move queue storage, countdown, watchdog and result register
module tmq_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tmq_pkg::dp_cmd_t           cmd_i,
  input  logic [tmq_pkg::OP_W-1:0]   op_i,
  input  logic [tmq_pkg::ACT_W-1:0]  move_action_i,
  input  logic [tmq_pkg::TICK_W-1:0] move_ticks_i,
  input  logic                       hb_limit_we_i,
  input  logic [tmq_pkg::TICK_W-1:0] hb_limit_i,
  output logic                       push_taken_o,
  output logic                       motors_stopped_o,
  output logic                       move_started_o,
  output logic [tmq_pkg::ACT_W-1:0]  started_action_o,
  output logic                       now_ready_o,
  output logic                       watchdog_fired_o,
  output logic [tmq_pkg::QCNT_W-1:0] queued_count_o
);
  import tmq_pkg::*;

  op_e               op_q;
  logic [ACT_W-1:0]  act_q;
  logic [TICK_W-1:0] ticks_q;

  logic [ACT_W-1:0]  q_act_q [QUEUE_DEPTH];
  logic [TICK_W-1:0] q_dur_q [QUEUE_DEPTH];

  logic [PTR_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic              running_q, running_d;
  logic [TICK_W-1:0] remain_q, remain_d;
  logic [TICK_W-1:0] since_q, since_d;
  logic [TICK_W-1:0] limit_q;

  logic              taken_q, stopped_q, started_q, ready_q, fired_q;
  logic [ACT_W-1:0]  s_act_q;
  logic              taken_d, stopped_d, started_d, ready_d, fired_d;
  logic [ACT_W-1:0]  s_act_d;

  logic [CNT_W:0]    tail_sum;
  logic [PTR_W-1:0]  tail_idx;
  logic [PTR_W-1:0]  head_next;
  logic [TICK_W-1:0] remain_dec;
  logic              wr_en;

  assign tail_sum  = (CNT_W+1)'(head_q) + (CNT_W+1)'(fill_q);
  assign tail_idx  = (tail_sum >= (CNT_W+1)'(QUEUE_DEPTH)) ?
                     PTR_W'(tail_sum - (CNT_W+1)'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
  assign head_next = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign remain_dec = (remain_q != '0) ? remain_q - 1'b1 : '0;

  always_comb begin
    head_d    = head_q;
    fill_d    = fill_q;
    running_d = running_q;
    remain_d  = remain_q;
    since_d   = since_q;
    wr_en     = 1'b0;
    taken_d   = 1'b0;
    stopped_d = 1'b0;
    started_d = 1'b0;
    ready_d   = 1'b0;
    fired_d   = 1'b0;
    s_act_d   = '0;
    case (op_q)
      OP_PUSH: begin
        if (fill_q < CNT_W'(QUEUE_DEPTH)) begin
          wr_en   = 1'b1;
          fill_d  = fill_q + 1'b1;
          taken_d = 1'b1;
        end
      end
      OP_START: begin
        if (!running_q && fill_q != '0) begin
          started_d = 1'b1;
          s_act_d   = q_act_q[head_q];
          remain_d  = q_dur_q[head_q];
          running_d = 1'b1;
          head_d    = head_next;
          fill_d    = fill_q - 1'b1;
        end
      end
      OP_HEARTBEAT: begin
        since_d = '0;
      end
      OP_TICK: begin
        since_d = (since_q == TICK_MAX) ? since_q : since_q + 1'b1;
        if (running_q) begin
          remain_d = remain_dec;
          if (remain_dec == '0) begin
            running_d = 1'b0;
            stopped_d = 1'b1;
            if (fill_q != '0) begin
              started_d = 1'b1;
              s_act_d   = q_act_q[head_q];
              remain_d  = q_dur_q[head_q];
              running_d = 1'b1;
              head_d    = head_next;
              fill_d    = fill_q - 1'b1;
            end else begin
              ready_d = 1'b1;
            end
          end
        end
        if (running_d && since_d >= limit_q) begin
          running_d = 1'b0;
          fill_d    = '0;
          remain_d  = '0;
          stopped_d = 1'b1;
          fired_d   = 1'b1;
        end
      end
      default: begin
        since_d = since_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= op_e'(op_i);
      act_q   <= move_action_i;
      ticks_q <= move_ticks_i;
    end
    if (cmd_i.execute && wr_en) begin
      q_act_q[tail_idx] <= act_q;
      q_dur_q[tail_idx] <= ticks_q;
    end
    if (cmd_i.execute) begin
      taken_q   <= taken_d;
      stopped_q <= stopped_d;
      started_q <= started_d;
      ready_q   <= ready_d;
      fired_q   <= fired_d;
      s_act_q   <= s_act_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      fill_q    <= '0;
      running_q <= 1'b0;
      remain_q  <= '0;
      since_q   <= '0;
      limit_q   <= HB_LIMIT_RESET;
    end else begin
      if (hb_limit_we_i) begin
        limit_q <= hb_limit_i;
      end
      if (cmd_i.execute) begin
        head_q    <= head_d;
        fill_q    <= fill_d;
        running_q <= running_d;
        remain_q  <= remain_d;
        since_q   <= since_d;
      end
    end
  end

  assign push_taken_o     = taken_q;
  assign motors_stopped_o = stopped_q;
  assign move_started_o   = started_q;
  assign started_action_o = s_act_q;
  assign now_ready_o      = ready_q;
  assign watchdog_fired_o = fired_q;
  assign queued_count_o   = QCNT_W'(fill_q);

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue fill beyond depth");

  a_fire_flushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.execute && fired_d |=> fill_q == '0 && !running_q && stopped_q)
    else $error("watchdog did not flush and stop");

  a_fill_only_on_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.execute |=> $stable(fill_q) && $stable(head_q))
    else $error("queue pointers moved outside execute");
endmodule

>>> hw/rtl/timed_move_queue_with_watchdog.sv
// top level of the timed move queue with heartbeat watchdog
// Eight-entry queue of motor moves (action code and duration in ticks) driven by
// push, start, heartbeat and tick commands, with one result per command transaction.
// Each transaction is captured, then the queue, countdown and watchdog are updated,
// and the result is presented until it is taken, in the controller's state order.
// heartbeat_limit is written through hb_limit_we_i / hb_limit_i, resets to 1000
// and should change only while idle.
module timed_move_queue_with_watchdog (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  tmq_req_if.sink                    req_i,
  tmq_rsp_if.source                  rsp_o,
  input  logic                       hb_limit_we_i,
  input  logic [tmq_pkg::TICK_W-1:0] hb_limit_i
);
  import tmq_pkg::*;

  dp_cmd_t cmd;

  tmq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  tmq_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .op_i             (req_i.op),
    .move_action_i    (req_i.move_action),
    .move_ticks_i     (req_i.move_ticks),
    .hb_limit_we_i    (hb_limit_we_i),
    .hb_limit_i       (hb_limit_i),
    .push_taken_o     (rsp_o.push_taken),
    .motors_stopped_o (rsp_o.motors_stopped),
    .move_started_o   (rsp_o.move_started),
    .started_action_o (rsp_o.started_action),
    .now_ready_o      (rsp_o.now_ready),
    .watchdog_fired_o (rsp_o.watchdog_fired),
    .queued_count_o   (rsp_o.queued_count)
  );
endmodule
